>>> rtl/fpfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfl_pkg
// Shared types and constants for the fixed-size pool free list.
// ----------------------------------------------------------------------------
package fpfl_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]  MAX_COUNT       = CNT_W'(MAX_CHUNKS);
    localparam logic [ADDR_W-1:0] BASE_RESET      = '0;
    localparam logic [SIZE_W-1:0] CHUNK_BYTES_RST = SIZE_W'(64);
    localparam logic [CNT_W-1:0]  CHUNK_COUNT_RST = CNT_W'(16);

    // operation codes (s_tuser)
    localparam logic [1:0] FUNC_ALLOC    = 2'd0;
    localparam logic [1:0] FUNC_FREE     = 2'd1;
    localparam logic [1:0] FUNC_FREE_ALL = 2'd2;

    // result status codes (m_tuser)
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd2;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [IDX_W-1:0] idx;
    } stack_cmd_t;

    typedef struct packed {
        logic             nonempty;
        logic [IDX_W-1:0] top;
    } stack_stat_t;

endpackage

>>> rtl/fpfl_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfl_stack
// Linked LIFO of freed chunk indexes. The link memory has a registered read;
// the top's link and the link below it are kept ready so pops run
// back to back.
// ----------------------------------------------------------------------------
module fpfl_stack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fpfl_pkg::stack_cmd_t cmd,
    output fpfl_pkg::stack_stat_t stat
);
    import fpfl_pkg::*;

    logic [IDX_W-1:0] link_mem [MAX_CHUNKS];

    logic             nonempty_reg, nonempty_next;
    logic [IDX_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0] l1_reg, l1_next;     // link of top
    logic [IDX_W-1:0] rd_data_reg;         // link of l1, from memory
    logic             byp_hit_reg;
    logic [IDX_W-1:0] byp_data_reg;
    logic [IDX_W-1:0] l2;
    logic             wr_en;
    logic [IDX_W-1:0] wr_data;

    assign l2      = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign wr_en   = cmd.push;
    assign wr_data = nonempty_reg ? top_reg : cmd.idx;

    always_comb begin
        nonempty_next = nonempty_reg;
        top_next      = top_reg;
        l1_next       = l1_reg;
        if (cmd.clear) begin
            nonempty_next = 1'b0;
            top_next      = '0;
        end else if (cmd.push) begin
            nonempty_next = 1'b1;
            top_next      = cmd.idx;
            l1_next       = wr_data;
        end else if (cmd.pop) begin
            // a self-link marks the bottom of the stack
            if (l1_reg == top_reg) begin
                nonempty_next = 1'b0;
            end else begin
                top_next = l1_reg;
                l1_next  = l2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= 1'b0;
            top_reg      <= '0;
            byp_hit_reg  <= 1'b0;
        end else begin
            nonempty_reg <= nonempty_next;
            top_reg      <= top_next;
            byp_hit_reg  <= wr_en && (cmd.idx == l1_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[cmd.idx] <= wr_data;
        end
        rd_data_reg  <= link_mem[l1_next];
        byp_data_reg <= wr_data;
        l1_reg       <= l1_next;
    end

    assign stat.nonempty = nonempty_reg;
    assign stat.top      = top_reg;

endmodule

>>> rtl/fixed_pool_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_pool_free_list
// Pool allocator for equal-sized chunks with a LIFO free list.
// ----------------------------------------------------------------------------
// Takes one operation per clock (allocate, free, free all) and returns one
// result per operation in the cycle after acceptance, from a single output
// register; s_tready only drops while that register holds a result the
// consumer has not taken. Freed chunks are chained through a 256 x 8 link
// memory with a registered read; the top of the chain and the next link are
// held in registers so that allocates and frees can follow each other every
// cycle. Allocates with no freed chunk waiting hand out never-issued chunks from
// chunk_count-1 (as of reset or last free all) down. The address path is one
// 8 x 16 multiply and a 32-bit add. No clearing pass is needed after reset.
module fixed_pool_free_list (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    // operations
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] release_index
    input  logic [1:0]                          s_tuser,  // [1:0] func
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,  // [7:0] granted_index,
                                                          // [39:8] granted_address
    output logic [1:0]                          m_tuser   // [1:0] status
);
    import fpfl_pkg::*;

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] chunk_bytes_reg;
    logic [CNT_W-1:0]  chunk_count_reg;
    logic [CNT_W-1:0]  eff_count;

    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic              m_valid_reg;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  gidx_reg, gidx_next;
    logic [ADDR_W-1:0] gaddr_reg, gaddr_next;

    logic              acc;
    logic [1:0]        func;
    logic [IDX_W-1:0]  rel;
    logic              range_err;
    logic [IDX_W-1:0]  alloc_idx;
    logic              alloc_ok;
    logic [IDX_W+SIZE_W-1:0] offset;

    stack_cmd_t  cmd;
    stack_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg        <= BASE_RESET;
            chunk_bytes_reg <= CHUNK_BYTES_RST;
            chunk_count_reg <= CHUNK_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_reg        <= cfg_data[ADDR_W-1:0];
                CFG_CHUNK_BYTES:  chunk_bytes_reg <= cfg_data[SIZE_W-1:0];
                CFG_CHUNK_COUNT:  chunk_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_count = (chunk_count_reg > MAX_COUNT) ? MAX_COUNT : chunk_count_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign func     = s_tuser;
    assign rel      = s_tdata[IDX_W-1:0];

    assign range_err = ({1'b0, rel} >= eff_count);
    assign alloc_ok  = stat.nonempty || (fresh_reg != '0);
    assign alloc_idx = stat.nonempty ? stat.top : IDX_W'(fresh_reg - CNT_W'(1));
    assign offset    = alloc_idx * chunk_bytes_reg;

    always_comb begin
        cmd         = '0;
        cmd.idx     = rel;
        fresh_next  = fresh_reg;
        status_next = STATUS_OK;
        gidx_next   = '0;
        gaddr_next  = '0;
        case (func)
            FUNC_ALLOC: begin
                if (alloc_ok) begin
                    gidx_next  = alloc_idx;
                    gaddr_next = base_reg + ADDR_W'(offset);
                    if (stat.nonempty) begin
                        cmd.pop = acc;
                    end else if (acc) begin
                        fresh_next = fresh_reg - CNT_W'(1);
                    end
                end else begin
                    status_next = STATUS_NO_MEMORY;
                end
            end
            FUNC_FREE: begin
                if (range_err) begin
                    status_next = STATUS_BAD_INDEX;
                end else begin
                    cmd.push = acc;
                end
            end
            FUNC_FREE_ALL: begin
                cmd.clear = acc;
                if (acc) begin
                    fresh_next = eff_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg   <= CHUNK_COUNT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            fresh_reg <= fresh_next;
            if (acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            status_reg <= status_next;
            gidx_reg   <= gidx_next;
            gaddr_reg  <= gaddr_next;
        end
    end

    fpfl_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {gaddr_reg, gidx_reg};
    assign m_tuser  = status_reg;

    // error results never carry a grant
    a_err_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != STATUS_OK) |-> (gidx_reg == '0 && gaddr_reg == '0))
        else $error("error result carries a grant");

    // an accepted in-range free becomes the top of the stack
    a_free_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && func == FUNC_FREE && !range_err) |=> (stat.nonempty && stat.top == $past(rel)))
        else $error("freed chunk is not on top of the stack");

    // free all empties the stack
    a_free_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && func == FUNC_FREE_ALL) |=> !stat.nonempty)
        else $error("stack not empty after free all");

    // fresh count never exceeds the pool capacity
    a_fresh_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= MAX_COUNT)
        else $error("fresh count beyond capacity");

endmodule

>>> tb/sv/fixed_pool_free_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_pool_free_list_tb
// Self-checking bench for the pool allocator free list.
// ----------------------------------------------------------------------------
// Drives allocate, free and free-all operations under several register
// settings, with random gaps and stalls on both streams. A scoreboard keeps
// its own copy of the free stack, the fresh-chunk count and the registers,
// predicts the status, index and address of every operation and compares each
// result transaction against the oldest prediction.
module fixed_pool_free_list_tb;

    import fpfl_pkg::*;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam int         PHASES        = 8;
    localparam int         PHASE_OPS     = 230;

    class pool_grant_scoreboard;
        typedef struct {
            logic [1:0]  status;
            logic [7:0]  index;
            logic [31:0] address;
        } grant_t;

        grant_t      expected_grants[$];
        logic [7:0]  next_link [MAX_CHUNKS];
        logic [7:0]  stack_top;
        logic        stack_nonempty;
        logic [8:0]  fresh_left;
        logic [31:0] base_addr;
        logic [15:0] chunk_stride;
        logic [8:0]  chunk_total;
        int          errors;

        function logic [8:0] usable_chunks();
            return (chunk_total > MAX_COUNT) ? MAX_COUNT : chunk_total;
        endfunction

        function void reset_state();
            base_addr      = BASE_RESET;
            chunk_stride   = CHUNK_BYTES_RST;
            chunk_total    = CHUNK_COUNT_RST;
            stack_top      = '0;
            stack_nonempty = 1'b0;
            fresh_left     = usable_chunks();
            foreach (next_link[i]) next_link[i] = '0;
            errors         = 0;
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_BASE_ADDRESS: base_addr    = data;
                CFG_CHUNK_BYTES:  chunk_stride = data[15:0];
                CFG_CHUNK_COUNT:  chunk_total  = data[8:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted operation to the shadow pool and queues its result.
        function void note_operation(logic [1:0] func, logic [7:0] rel);
            grant_t     g;
            logic [7:0] idx;
            logic       granted;
            g.status  = STATUS_OK;
            g.index   = '0;
            g.address = '0;
            idx       = '0;
            granted   = 1'b0;
            case (func)
                FUNC_ALLOC: begin
                    if (stack_nonempty) begin
                        idx     = stack_top;
                        granted = 1'b1;
                        // a self-link marks the bottom of the stack
                        if (next_link[idx] == idx) stack_nonempty = 1'b0;
                        else stack_top = next_link[idx];
                    end else if (fresh_left != 0) begin
                        fresh_left = fresh_left - 1'b1;
                        idx        = fresh_left[7:0];
                        granted    = 1'b1;
                    end else begin
                        g.status = STATUS_NO_MEMORY;
                    end
                    if (granted) begin
                        g.index   = idx;
                        g.address = base_addr + 32'(idx) * 32'(chunk_stride);
                    end
                end
                FUNC_FREE: begin
                    if ({1'b0, rel} >= usable_chunks()) begin
                        g.status = STATUS_BAD_INDEX;
                    end else begin
                        next_link[rel] = stack_nonempty ? stack_top : rel;
                        stack_top      = rel;
                        stack_nonempty = 1'b1;
                    end
                end
                FUNC_FREE_ALL: begin
                    stack_top      = '0;
                    stack_nonempty = 1'b0;
                    fresh_left     = usable_chunks();
                end
                default: ;
            endcase
            expected_grants.push_back(g);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_grant(logic [1:0] status, logic [7:0] index, logic [31:0] address);
            grant_t g;
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d index %0d addr %h",
                                          status, index, address));
                return;
            end
            g = expected_grants.pop_front();
            if (status !== g.status)
                report_mismatch($sformatf("status got %0d exp %0d", status, g.status));
            if (index !== g.index)
                report_mismatch($sformatf("granted_index got %0d exp %0d", index, g.index));
            if (address !== g.address)
                report_mismatch($sformatf("granted_address got %h exp %h",
                                          address, g.address));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] release_index
    logic [1:0]            s_tuser;   // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // [7:0] granted_index, [39:8] granted_address
    logic [1:0]            m_tuser;   // [1:0] status

    pool_grant_scoreboard sb;
    int                   idle_cycles;
    bit                   rx_hold_req;
    bit                   tx_dense;

    fixed_pool_free_list uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Transaction monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_grant(m_tuser, m_tdata[7:0], m_tdata[39:8]);
            if (s_tvalid && s_tready)
                sb.note_operation(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Result consumer: random ready windows, gaps, and a long hold on request
    initial begin
        int busy;
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                busy = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                    : $urandom_range(1, 8);
                repeat (busy) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Leaves s_tvalid high when no gap follows, so back-to-back ops stream.
    task automatic send_op(logic [1:0] func, logic [7:0] rel);
        int gap;
        s_tuser  <= func;
        s_tdata  <= rel;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = tx_dense ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_op(int alloc_pct);
        int         r;
        logic [8:0] lim;
        logic [7:0] rel;
        r   = $urandom_range(0, 99);
        lim = sb.usable_chunks();
        if (r < alloc_pct) begin
            send_op(FUNC_ALLOC, 8'($urandom));
        end else if (r < 94) begin
            if ($urandom_range(0, 9) == 0) rel = 8'($urandom);
            else rel = 8'($urandom_range(0, lim - 1));
            send_op(FUNC_FREE, rel);
        end else if (r < 97) begin
            send_op(FUNC_FREE_ALL, 8'($urandom));
        end else begin
            send_op(FUNC_UNUSED, 8'($urandom));
        end
    endtask

    // Sender stops and waits until every outstanding result has been taken.
    // The first edge lets the monitor log a transaction taken at the last one.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [31:0] base, logic [15:0] csize, logic [8:0] ccount);
        settle();
        cfg_write(CFG_BASE_ADDRESS, base);
        cfg_write(CFG_CHUNK_BYTES, {16'h0, csize});
        cfg_write(CFG_CHUNK_COUNT, {23'h0, ccount});
    endtask

    initial begin
        int          phase;
        int          n;
        int          alloc_pct;
        logic [31:0] base;
        logic [15:0] csize;
        logic [8:0]  ccount;

        sb = new;
        sb.reset_state();
        idle_cycles = 0;
        rx_hold_req = 1'b0;
        tx_dense    = 1'b0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under the reset register values
        send_op(FUNC_UNUSED, 8'hFF);
        send_op(FUNC_FREE, 8'd15);       // bottom of stack links to itself
        send_op(FUNC_FREE, 8'd15);       // double free of the top chunk
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_ALLOC, 8'hFF);      // stack empty, fresh chunk
        send_op(FUNC_FREE, 8'd16);       // first index past the count
        send_op(FUNC_FREE, 8'd255);
        send_op(FUNC_FREE, 8'd0);
        send_op(FUNC_FREE, 8'd5);
        send_op(FUNC_ALLOC, 8'h55);
        send_op(FUNC_ALLOC, 8'hAA);
        send_op(FUNC_FREE, 8'd3);
        send_op(FUNC_FREE, 8'd7);
        send_op(FUNC_FREE, 8'd3);        // double free below the top
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_FREE_ALL, 8'h00);
        send_op(FUNC_ALLOC, 8'h00);

        // largest pool, address wraps at 32 bits
        configure(32'hFFFF_FFF0, 16'hFFFF, 9'd256);
        send_op(FUNC_FREE_ALL, 8'h00);
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_FREE, 8'd255);
        // shrink to one chunk without free-all: fresh count is kept
        settle();
        cfg_write(CFG_CHUNK_COUNT, 32'd1);
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_FREE, 8'd254);
        send_op(FUNC_FREE_ALL, 8'h00);
        send_op(FUNC_ALLOC, 8'h00);
        send_op(FUNC_ALLOC, 8'h00);      // out of memory

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin base = 32'h0;        csize = 16'd8;     ccount = 9'd1;   end
                1: begin base = 32'hFFFF_FFFF; csize = 16'hFFFF; ccount = 9'd256; end
                2: begin
                    base   = $urandom;
                    csize  = 16'($urandom_range(8, 64));
                    ccount = 9'($urandom_range(2, 8));
                end
                3: begin base = $urandom; csize = 16'($urandom_range(8, 65535)); ccount = 9'd256; end
                default: begin
                    base   = $urandom;
                    csize  = 16'($urandom_range(8, 65535));
                    ccount = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(1, 24))
                                                         : 9'($urandom_range(1, 256));
                end
            endcase
            configure(base, csize, ccount);
            if ($urandom_range(0, 3) != 0) send_op(FUNC_FREE_ALL, 8'($urandom));
            tx_dense = (phase % 3 == 1);
            case ($urandom_range(0, 2))
                0:       alloc_pct = 30;
                1:       alloc_pct = 50;
                default: alloc_pct = 70;
            endcase
            for (n = 0; n < PHASE_OPS; n++) begin
                // consumer holds off while operations keep coming
                if (phase == 2 && n == 40) rx_hold_req = 1'b1;
                if (phase == 4 && n == 120) settle();
                send_random_op(alloc_pct);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/fpfl_pkg.sv
rtl/fpfl_stack.sv
rtl/fixed_pool_free_list.sv
tb/sv/fixed_pool_free_list_tb.sv
